// File: sv/fdm_pkg.sv
package fdm_pkg;

    // Default word width of the dividend and the quotient.
    localparam int FDM_DATA_WIDTH = 64;

    // Control that travels down the pipeline next to the data of one word.
    typedef struct packed {
        logic valid;
        logic neg;
        logic zero;
    } fdm_ctl_t;

endpackage

// File: sv/fdm_req_if.sv
interface fdm_req_if
    import fdm_pkg::*;
#(
    parameter int DATA_WIDTH = FDM_DATA_WIDTH
);
    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] dividend;
    logic [DATA_WIDTH-2:0] divisor;

    modport source (output valid, output dividend, output divisor, input ready);
    modport sink (input valid, input dividend, input divisor, output ready);
endinterface

// File: sv/fdm_rsp_if.sv
interface fdm_rsp_if
    import fdm_pkg::*;
#(
    parameter int DATA_WIDTH = FDM_DATA_WIDTH
);
    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] quotient;
    logic [DATA_WIDTH-2:0] modulo;
    logic                  divide_by_zero;

    modport source (output valid, output quotient, output modulo, output divide_by_zero,
                    input ready);
    modport sink (input valid, input quotient, input modulo, input divide_by_zero,
                  output ready);
endinterface

// File: sv/floored_divide_modulo.sv
// Floored signed divide and modulo, one word in and one word out per operation.
// The req channel carries a signed dividend and an unsigned divisor one bit
// narrower; the rsp channel returns the quotient rounded toward minus infinity,
// the modulo in the range zero to divisor minus one, and a divide-by-zero flag.
// A zero divisor sets the flag and returns zero in both result fields.
// The accepting edge loads the magnitude register in the input stage, DATA_WIDTH
// restoring stages each retire one quotient bit with one subtract and compare,
// and a final fix stage applies the sign correction. Throughput is one word per
// cycle while the skid register is empty; the depth is set by the one quotient
// bit that each stage resolves.
// When the receiver stalls, the result in the last stage drops into a skid
// register and the pipeline freezes in the cycle after; req.ready is low while the
// skid register is full, so no word is lost or repeated. Reset clears all
// valid bits, the skid register's among them, and req.ready is high out of reset.
module floored_divide_modulo
    import fdm_pkg::*;
#(
    parameter int DATA_WIDTH = FDM_DATA_WIDTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    fdm_req_if.sink   req,
    fdm_rsp_if.source rsp
);

    // Pipeline taps between the restoring stages; entry 0 comes from the input stage.
    fdm_ctl_t              ctl_w [0:DATA_WIDTH];
    logic [DATA_WIDTH-2:0] rem_w [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] dq_w  [0:DATA_WIDTH];
    logic [DATA_WIDTH-2:0] div_w [0:DATA_WIDTH];

    logic                  adv;
    logic                  fix_valid;
    logic [DATA_WIDTH-1:0] fix_quo;
    logic [DATA_WIDTH-2:0] fix_mod;
    logic                  fix_dbz;

    logic                  skid_valid_reg;
    logic                  skid_valid_next;
    logic [DATA_WIDTH-1:0] skid_quo_reg;
    logic [DATA_WIDTH-2:0] skid_mod_reg;
    logic                  skid_dbz_reg;

    // The whole pipeline moves together; it only holds while the skid register is
    // occupied, which is a registered condition and keeps req.ready off any long path.
    assign adv       = !skid_valid_reg;
    assign req.ready = adv;

    fdm_prep #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .valid    (req.valid),
        .dividend (req.dividend),
        .divisor  (req.divisor),
        .ctl      (ctl_w[0]),
        .mag      (dq_w[0]),
        .div      (div_w[0])
    );

    // The partial remainder starts at zero for every word.
    assign rem_w[0] = '0;

    for (genvar i = 0; i < DATA_WIDTH; i++)
    begin : g_stage
        fdm_div_stage #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_stage (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .ctl_in  (ctl_w[i]),
            .rem_in  (rem_w[i]),
            .dq_in   (dq_w[i]),
            .div_in  (div_w[i]),
            .ctl_out (ctl_w[i+1]),
            .rem_out (rem_w[i+1]),
            .dq_out  (dq_w[i+1]),
            .div_out (div_w[i+1])
        );
    end

    fdm_fix #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_fix (
        .clk            (clk),
        .rst_n          (rst_n),
        .adv            (adv),
        .ctl_in         (ctl_w[DATA_WIDTH]),
        .rem_in         (rem_w[DATA_WIDTH]),
        .q_in           (dq_w[DATA_WIDTH]),
        .div_in         (div_w[DATA_WIDTH]),
        .valid          (fix_valid),
        .quotient       (fix_quo),
        .modulo         (fix_mod),
        .divide_by_zero (fix_dbz)
    );

    // The skid register catches the finished word when the receiver stalls, in the
    // same cycle that the pipeline still advances, and drains once rsp.ready is seen.
    always_comb
    begin
        if (!skid_valid_reg)
        begin
            skid_valid_next = fix_valid && !rsp.ready;
        end
        else
        begin
            skid_valid_next = !rsp.ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_valid_reg)
        begin
            skid_quo_reg <= fix_quo;
            skid_mod_reg <= fix_mod;
            skid_dbz_reg <= fix_dbz;
        end
    end

    assign rsp.valid          = skid_valid_reg || fix_valid;
    assign rsp.quotient       = skid_valid_reg ? skid_quo_reg : fix_quo;
    assign rsp.modulo         = skid_valid_reg ? skid_mod_reg : fix_mod;
    assign rsp.divide_by_zero = skid_valid_reg ? skid_dbz_reg : fix_dbz;

    // A stalled finished word must land in the skid register.
    a_skid_capture: assert property (@(posedge clk) disable iff (!rst_n)
        fix_valid && !skid_valid_reg && !rsp.ready |=> skid_valid_reg)
        else $error("stalled result was not captured by the skid register");

    // While the skid register holds a word that is not taken, it keeps it unchanged.
    a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && !rsp.ready |=> skid_valid_reg && $stable(skid_quo_reg)
            && $stable(skid_mod_reg) && $stable(skid_dbz_reg))
        else $error("skid register lost or changed a stalled word");

    // A zero divisor always comes out with zero result fields.
    a_zero_results: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.divide_by_zero |-> rsp.quotient == '0 && rsp.modulo == '0)
        else $error("divide by zero returned nonzero results");

endmodule

// File: sv/fdm_prep.sv
module fdm_prep
    import fdm_pkg::*;
#(
    parameter int DATA_WIDTH = FDM_DATA_WIDTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  logic                  valid,
    input  logic [DATA_WIDTH-1:0] dividend,
    input  logic [DATA_WIDTH-2:0] divisor,
    output fdm_ctl_t              ctl,
    output logic [DATA_WIDTH-1:0] mag,
    output logic [DATA_WIDTH-2:0] div
);

    fdm_ctl_t              ctl_reg;
    fdm_ctl_t              ctl_next;
    logic [DATA_WIDTH-1:0] mag_reg;
    logic [DATA_WIDTH-1:0] mag_next;
    logic [DATA_WIDTH-2:0] div_reg;

    // The magnitude of the most negative dividend still fits as an unsigned word.
    always_comb
    begin
        ctl_next.valid = valid;
        ctl_next.neg   = dividend[DATA_WIDTH-1];
        ctl_next.zero  = (divisor == '0);
        mag_next       = dividend[DATA_WIDTH-1] ? ('0 - dividend) : dividend;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (adv)
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mag_reg <= mag_next;
            div_reg <= divisor;
        end
    end

    assign ctl = ctl_reg;
    assign mag = mag_reg;
    assign div = div_reg;

endmodule

// File: sv/fdm_div_stage.sv
module fdm_div_stage
    import fdm_pkg::*;
#(
    parameter int DATA_WIDTH = FDM_DATA_WIDTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  fdm_ctl_t              ctl_in,
    input  logic [DATA_WIDTH-2:0] rem_in,
    input  logic [DATA_WIDTH-1:0] dq_in,
    input  logic [DATA_WIDTH-2:0] div_in,
    output fdm_ctl_t              ctl_out,
    output logic [DATA_WIDTH-2:0] rem_out,
    output logic [DATA_WIDTH-1:0] dq_out,
    output logic [DATA_WIDTH-2:0] div_out
);

    fdm_ctl_t              ctl_reg;
    logic [DATA_WIDTH-2:0] rem_reg;
    logic [DATA_WIDTH-2:0] rem_next;
    logic [DATA_WIDTH-1:0] dq_reg;
    logic [DATA_WIDTH-1:0] dq_next;
    logic [DATA_WIDTH-2:0] div_reg;
    logic [DATA_WIDTH-1:0] trial;
    logic [DATA_WIDTH-1:0] diff;
    logic                  fits;

    // One restoring step: the top dividend bit shifts into the partial remainder and
    // the new quotient bit shifts in at the bottom of the same word.
    always_comb
    begin
        trial = {rem_in, dq_in[DATA_WIDTH-1]};
        diff  = trial - {1'b0, div_in};
        fits  = (trial >= {1'b0, div_in});
        rem_next = fits ? diff[DATA_WIDTH-2:0] : trial[DATA_WIDTH-2:0];
        dq_next  = {dq_in[DATA_WIDTH-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (adv)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg <= rem_next;
            dq_reg  <= dq_next;
            div_reg <= div_in;
        end
    end

    assign ctl_out = ctl_reg;
    assign rem_out = rem_reg;
    assign dq_out  = dq_reg;
    assign div_out = div_reg;

endmodule

// File: sv/fdm_fix.sv
module fdm_fix
    import fdm_pkg::*;
#(
    parameter int DATA_WIDTH = FDM_DATA_WIDTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  fdm_ctl_t              ctl_in,
    input  logic [DATA_WIDTH-2:0] rem_in,
    input  logic [DATA_WIDTH-1:0] q_in,
    input  logic [DATA_WIDTH-2:0] div_in,
    output logic                  valid,
    output logic [DATA_WIDTH-1:0] quotient,
    output logic [DATA_WIDTH-2:0] modulo,
    output logic                  divide_by_zero
);

    logic                  valid_reg;
    logic [DATA_WIDTH-1:0] quo_reg;
    logic [DATA_WIDTH-1:0] quo_next;
    logic [DATA_WIDTH-2:0] mod_reg;
    logic [DATA_WIDTH-2:0] mod_next;
    logic                  dbz_reg;
    logic                  nonzero_rem;

    // For a negative dividend the floored quotient is minus the ceiling of the
    // magnitude quotient: -(q + 1) is ~q when a remainder is left, else it is -q.
    always_comb
    begin
        nonzero_rem = (rem_in != '0);
        if (ctl_in.zero)
        begin
            quo_next = '0;
            mod_next = '0;
        end
        else if (!ctl_in.neg)
        begin
            quo_next = q_in;
            mod_next = rem_in;
        end
        else
        begin
            quo_next = nonzero_rem ? ~q_in : ('0 - q_in);
            mod_next = nonzero_rem ? (div_in - rem_in) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= ctl_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            quo_reg <= quo_next;
            mod_reg <= mod_next;
            dbz_reg <= ctl_in.zero;
        end
    end

    assign valid          = valid_reg;
    assign quotient       = quo_reg;
    assign modulo         = mod_reg;
    assign divide_by_zero = dbz_reg;

endmodule

// File: verif/tb_top.sv
module tb_top;
    import fdm_pkg::*;

    // The block is checked at its default width, which is also the width of the package.
    localparam int DW = FDM_DATA_WIDTH;

    // Clock period in time units, and a hard ceiling on the run length in cycles.
    // The ceiling is far above a slow but correct run of a little over a thousand words.
    localparam int CLK_PERIOD     = 20;
    localparam int TIMEOUT_CYCLES = 400000;

    // Number of random words that follow the directed words.
    localparam int RANDOM_WORDS = 1130;

    // Field extremes that the directed words use.
    localparam logic [DW-1:0] MOST_NEG    = {1'b1, {(DW-1){1'b0}}};
    localparam logic [DW-1:0] MOST_POS    = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-2:0] DIVISOR_MAX = {(DW-1){1'b1}};

    // One request word: the dividend and the divisor as they appear on the req channel.
    typedef struct packed {
        logic [DW-1:0] dividend;
        logic [DW-2:0] divisor;
    } operand_t;

    // One response word as the block should return it.
    typedef struct packed {
        logic [DW-1:0] quotient;
        logic [DW-2:0] modulo;
        logic          divide_by_zero;
    } quot_mod_t;

    logic clk = 1'b0;
    logic rst_n;

    fdm_req_if #(.DATA_WIDTH(DW)) req_if ();
    fdm_rsp_if #(.DATA_WIDTH(DW)) rsp_if ();

    floored_divide_modulo #(
        .DATA_WIDTH(DW)
    )
    uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // Words waiting to be offered on req, filled once by the stimulus block.
    operand_t operand_queue[$];

    // Predicted responses, in the order in which their request words were accepted.
    quot_mod_t quot_mod_due[$];

    int total_words   = 0;
    int words_sent    = 0;
    int words_checked = 0;
    int error_count   = 0;

    // What the checked words covered, reported at the end of the run.
    int zero_div_seen = 0;
    int neg_div_seen  = 0;
    int exact_seen    = 0;

    // Sender burst state: words left in the current burst and idle cycles still to insert.
    int run_left  = 0;
    int idle_left = 0;

    // Receiver stall state: a rotating 32-bit ready mask that is replaced whenever pattern_left runs out.
    logic [31:0] stall_pattern;
    int          pattern_pos  = 0;
    int          pattern_left = 0;

    always
    begin
        #(CLK_PERIOD / 2) clk = 1'b1;
        #(CLK_PERIOD / 2) clk = 1'b0;
    end

    // Floored division as the block defines it. A non-negative dividend is a plain
    // unsigned divide. A negative dividend is divided by its magnitude; when that leaves
    // a remainder, the truncated quotient is pushed one further toward minus infinity
    // and the remainder is reflected against the divisor so that it stays non-negative.
    // The magnitude of the most negative dividend is 2^(DW-1), which still fits an
    // unsigned DW-bit vector, so that case needs no special handling.
    function automatic quot_mod_t floor_div_mod(logic [DW-1:0] dividend,
                                                logic [DW-2:0] divisor);
        quot_mod_t     res;
        logic [DW-1:0] wide_div;
        logic [DW-1:0] mag;
        logic [DW-1:0] whole;
        logic [DW-1:0] part;
        logic [DW-1:0] reflected;
        res      = '0;
        wide_div = {1'b0, divisor};
        if (divisor == '0)
        begin
            // A zero divisor only raises the flag; both numeric fields stay zero.
            res.divide_by_zero = 1'b1;
        end
        else if (!dividend[DW-1])
        begin
            whole        = dividend / wide_div;
            part         = dividend % wide_div;
            res.quotient = whole;
            res.modulo   = part[DW-2:0];
        end
        else
        begin
            mag   = -dividend;
            whole = mag / wide_div;
            part  = mag % wide_div;
            if (part == '0)
            begin
                res.quotient = -whole;
            end
            else
            begin
                // The bitwise inverse of the magnitude quotient equals -(whole + 1).
                reflected    = wide_div - part;
                res.quotient = ~whole;
                res.modulo   = reflected[DW-2:0];
            end
        end
        return res;
    endfunction

    task automatic queue_word(input logic [DW-1:0] dividend, input logic [DW-2:0] divisor);
        operand_t op;
        op.dividend = dividend;
        op.divisor  = divisor;
        operand_queue.push_back(op);
    endtask

    // Request driver. At each rising edge it first records an accepted word, which is
    // where the predicted response is queued, and then decides what req carries for the
    // next cycle. A word that is still waiting for ready is held unchanged. Otherwise the
    // sender either sits out an idle cycle of the current gap or offers the next word.
    // Bursts run from one to forty words; a quarter of them are followed by no gap at all,
    // so long back-to-back stretches occur as well as idle gaps of a randomly drawn length.
    always @(posedge clk or negedge rst_n)
    begin : req_driver
        operand_t op;
        if (!rst_n)
        begin
            req_if.valid    <= 1'b0;
            req_if.dividend <= '0;
            req_if.divisor  <= '0;
            run_left  = $urandom_range(1, 40);
            idle_left = 0;
        end
        else
        begin
            if (req_if.valid && req_if.ready)
            begin
                quot_mod_due.push_back(floor_div_mod(req_if.dividend, req_if.divisor));
                words_sent++;
            end
            if (!req_if.valid || req_if.ready)
            begin
                if (idle_left > 0 || operand_queue.size() == 0)
                begin
                    if (idle_left > 0)
                        idle_left--;
                    req_if.valid <= 1'b0;
                end
                else
                begin
                    op = operand_queue.pop_front();
                    req_if.valid    <= 1'b1;
                    req_if.dividend <= op.dividend;
                    req_if.divisor  <= op.divisor;
                    if (run_left <= 1)
                    begin
                        run_left  = $urandom_range(1, 40);
                        idle_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                    begin
                        run_left--;
                    end
                end
            end
        end
    end

    // Response monitor. Every accepted response word is compared field by field with the
    // oldest prediction. The ready pattern is a rotating 32-bit mask; each new mask is
    // one of: always ready, mostly ready, half ready, or mostly stalled, so that the
    // block's skid register and pipeline freeze are exercised at every phase.
    always @(posedge clk or negedge rst_n)
    begin : rsp_monitor
        quot_mod_t want;
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
            stall_pattern = '1;
            pattern_pos   = 0;
            pattern_left  = 0;
        end
        else
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                if (quot_mod_due.size() == 0)
                begin
                    $error("unexpected response word: quotient %h, modulo %h, divide_by_zero %b",
                           rsp_if.quotient, rsp_if.modulo, rsp_if.divide_by_zero);
                    error_count++;
                end
                else
                begin
                    want = quot_mod_due.pop_front();
                    words_checked++;
                    if (rsp_if.quotient !== want.quotient)
                    begin
                        $error("quotient: expected %h, actual %h",
                               want.quotient, rsp_if.quotient);
                        error_count++;
                    end
                    if (rsp_if.modulo !== want.modulo)
                    begin
                        $error("modulo: expected %h, actual %h", want.modulo, rsp_if.modulo);
                        error_count++;
                    end
                    if (rsp_if.divide_by_zero !== want.divide_by_zero)
                    begin
                        $error("divide_by_zero: expected %b, actual %b",
                               want.divide_by_zero, rsp_if.divide_by_zero);
                        error_count++;
                    end
                    if (want.divide_by_zero)
                        zero_div_seen++;
                    else if (want.quotient[DW-1])
                        neg_div_seen++;
                    if (!want.divide_by_zero && want.modulo == '0)
                        exact_seen++;
                end
            end
            if (pattern_left == 0)
            begin
                pattern_left = $urandom_range(50, 300);
                case ($urandom_range(0, 3))
                    0:       stall_pattern = '1;
                    1:       stall_pattern = $urandom | $urandom;
                    2:       stall_pattern = $urandom;
                    default: stall_pattern = $urandom & $urandom;
                endcase
            end
            pattern_left--;
            rsp_if.ready <= stall_pattern[pattern_pos];
            pattern_pos = (pattern_pos + 1) % 32;
        end
    end

    // Stimulus and end of run. Directed words come first, then random words whose
    // divisor and dividend are drawn from separate classes so that small, mid-size and
    // full-width divisors each meet small, extreme, exact-multiple and fully random
    // dividends of both signs.
    initial
    begin : stimulus
        int              i;
        int              mult;
        int              d_sel;
        int              n_sel;
        logic [DW-2:0]   divisor;
        logic [DW-1:0]   dividend;
        rst_n <= 1'b0;

        // Zero divisor with zero, the most negative and the most positive dividend.
        queue_word('0, '0);
        queue_word(MOST_NEG, '0);
        queue_word(MOST_POS, '0);
        // Divisor one: the quotient is the dividend itself, including the most negative.
        queue_word('0, 1);
        queue_word(1, 1);
        queue_word('1, 1);
        queue_word(MOST_NEG, 1);
        queue_word(MOST_NEG + 1, 1);
        queue_word(MOST_POS, 1);
        // Largest divisor against the dividend extremes; modulo reaches its top value.
        queue_word(MOST_NEG, DIVISOR_MAX);
        queue_word(MOST_POS, DIVISOR_MAX);
        queue_word(MOST_POS - 1, DIVISOR_MAX);
        queue_word('1, DIVISOR_MAX);
        // Negative dividends that divide exactly and ones that leave a remainder, then a positive one.
        queue_word(MOST_NEG, 2);
        queue_word(MOST_NEG, 3);
        queue_word(-64'sd7, 2);
        queue_word(-64'sd6, 3);
        queue_word(-64'sd7, 3);
        queue_word('1, 2);
        queue_word(64'd7, 2);

        for (i = 0; i < RANDOM_WORDS; i++)
        begin
            d_sel = $urandom_range(0, 15);
            if (d_sel == 0)
                divisor = '0;
            else if (d_sel == 1)
                divisor = DIVISOR_MAX;
            else if (d_sel <= 6)
                divisor = (DW-1)'($urandom_range(1, 16));
            else if (d_sel <= 10)
                divisor = {{(DW-33){1'b0}}, $urandom};
            else
                divisor = (DW-1)'({$urandom, $urandom});

            n_sel = $urandom_range(0, 7);
            case (n_sel)
                0:
                begin
                    // Near an exact multiple of the divisor, on either side of zero.
                    mult     = int'($urandom_range(0, 200)) - 100;
                    dividend = 64'(mult) * {1'b0, divisor} + 64'(int'($urandom_range(0, 2)) - 1);
                end
                1:
                begin
                    dividend = 64'(int'($urandom_range(0, 64)) - 32);
                end
                2:
                begin
                    case ($urandom_range(0, 4))
                        0:       dividend = MOST_NEG;
                        1:       dividend = MOST_POS;
                        2:       dividend = '1;
                        3:       dividend = '0;
                        default: dividend = 1;
                    endcase
                end
                default:
                begin
                    dividend = {$urandom, $urandom};
                end
            endcase
            queue_word(dividend, divisor);
        end
        total_words = operand_queue.size();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Every word accepted and every predicted response returned.
        while (words_sent != total_words || quot_mod_due.size() != 0)
            @(posedge clk);

        // Let the pipeline empty out so that a stray extra response would still be seen.
        repeat (DW + 8) @(posedge clk);

        if (quot_mod_due.size() != 0)
        begin
            $error("%0d predicted response words never arrived", quot_mod_due.size());
            error_count += quot_mod_due.size();
        end

        $display("Checked %0d response words: %0d with a zero divisor, %0d with a negative quotient,",
                 words_checked, zero_div_seen, neg_div_seen);
        $display("and %0d that divided exactly; %0d field mismatches or stray words.",
                 exact_seen, error_count);
        if (error_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    // Watchdog in case the block stops accepting or returning words.
    initial
    begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("tb_top: done, errors");
        $finish;
    end

endmodule
